/* rtl/assert_macros.svh */
// assertion macros for the rtl files of the range-add fenwick block
// no dependencies; included by modules that carry concurrent checks
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled while reset is low
`define ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, disabled while reset is low
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* rtl/rfw_pkg.sv */
// types and constants of the range-add / range-sum fenwick block
// no dependencies; used by range_add_range_sum_fenwick
package rfw_pkg;

  localparam int POS_W  = 11;
  localparam int VAL_W  = 32;
  localparam int SUM_W  = 64;
  localparam int REQ_W  = 2;
  localparam int PROD_W = VAL_W + POS_W;

  localparam int CFG_ADDR_W = 3;
  localparam int CFG_DATA_W = 32;

  typedef logic [REQ_W-1:0]        req_t;
  typedef logic [POS_W-1:0]        pos_t;
  typedef logic signed [VAL_W-1:0] val_t;
  typedef logic signed [SUM_W-1:0] sum_t;
  typedef logic [CFG_ADDR_W-1:0]   cfg_addr_t;
  typedef logic [CFG_DATA_W-1:0]   cfg_data_t;
  typedef logic [CFG_ADDR_W-3:0]   reg_idx_t;

  localparam req_t REQ_ADD   = 2'd0;
  localparam req_t REQ_QUERY = 2'd1;
  localparam req_t REQ_CLEAR = 2'd2;

  localparam reg_idx_t REG_ACTIVE_SIZE = 1'b0;
  localparam pos_t     ACTIVE_SIZE_RST = 11'd1024;

endpackage

/* rtl/rfw_ram.sv */
// generic single-write, single-read ram with registered read data
// no dependencies; used for both fenwick stores
module rfw_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 1026
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

/* rtl/range_add_range_sum_fenwick.sv */
// Range-add / range-sum block on two fenwick stores (offset and slope), 64-bit
// wrapping sums. Depends on rfw_pkg, rfw_ram and assert_macros.svh.
//
// A request adds a signed value to positions left..right, returns the sum over
// left..right, or clears both stores. Work runs one request at a time through
// a sequencer with one shared 32x11 multiplier and one read-modify-write per
// index on the store rams (both stores walk the same index path together).
// An add takes 2 walks, each a multiply followed by the fenwick upward walk,
// first from left, then from right+1. A query takes 2 walks, each the fenwick
// downward walk over popcount(index) indices, from right, then from left-1,
// followed by a multiply, plus a final step to post the result. A clear
// request, and the sweep after reset, write all MAX_POSITIONS+2 store entries,
// during which in_stall is high; active_size writes are taken at any time.
module range_add_range_sum_fenwick #(
  parameter int MAX_POSITIONS = 1024
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  rfw_pkg::req_t         in_req_type,
  input  rfw_pkg::pos_t         in_left,
  input  rfw_pkg::pos_t         in_right,
  input  rfw_pkg::val_t         in_value,
  output logic                  out_valid,
  input  logic                  out_stall,
  output rfw_pkg::sum_t         out_range_sum,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  rfw_pkg::cfg_addr_t    paddr,
  input  rfw_pkg::cfg_data_t    pwdata,
  output rfw_pkg::cfg_data_t    prdata,
  output logic                  pready
);
  import rfw_pkg::*;

  `include "assert_macros.svh"

  localparam int DEPTH  = MAX_POSITIONS + 2;
  localparam int AW     = $clog2(DEPTH);
  localparam int IDX_A  = $clog2(MAX_POSITIONS + 3);
  localparam int IDX_W  = ((IDX_A > POS_W + 1) ? IDX_A : POS_W + 1) + 1;

  localparam logic [3:0] ST_CLEAR   = 4'd0;
  localparam logic [3:0] ST_IDLE    = 4'd1;
  localparam logic [3:0] ST_MUL_LO  = 4'd2;
  localparam logic [3:0] ST_MUL_HI  = 4'd3;
  localparam logic [3:0] ST_FIN     = 4'd4;
  localparam logic [3:0] ST_UPD_RD  = 4'd5;
  localparam logic [3:0] ST_UPD_WR  = 4'd6;
  localparam logic [3:0] ST_QRY_RD  = 4'd7;
  localparam logic [3:0] ST_QRY_ACC = 4'd8;
  localparam logic [3:0] ST_OUT     = 4'd9;

  logic [3:0]       state_r, state_nxt;
  req_t             req_r, req_nxt;
  pos_t             left_r, left_nxt;
  pos_t             right_r, right_nxt;
  logic [VAL_W-1:0] x_r, x_nxt;
  logic             walk_r, walk_nxt;
  logic [IDX_W-1:0] id_r, id_nxt;
  logic             hit_r, hit_nxt;
  logic [SUM_W-1:0] amt_o_r, amt_o_nxt;
  logic [SUM_W-1:0] amt_s_r, amt_s_nxt;
  logic [SUM_W-1:0] acc_o_r, acc_o_nxt;
  logic [SUM_W-1:0] acc_s_r, acc_s_nxt;
  logic [SUM_W-1:0] prod_r, prod_nxt;
  logic [SUM_W-1:0] hi_r, hi_nxt;
  logic [AW-1:0]    clr_addr_r, clr_addr_nxt;
  pos_t             size_r;
  logic             out_valid_r, out_valid_nxt;
  logic [SUM_W-1:0] out_sum_r, out_sum_nxt;

  logic             in_accept;
  logic             is_query;
  logic [IDX_W-1:0] size_cap;
  logic [IDX_W-1:0] limit;
  logic [IDX_W-1:0] id_low;
  logic [IDX_W-1:0] upd_nid;
  logic [IDX_W-1:0] qry_nid;
  logic [SUM_W-1:0] x64;
  logic [SUM_W-1:0] mul_a64;
  logic [VAL_W-1:0] mul_a32;
  pos_t             mul_b;
  logic [PROD_W-1:0] mul_p;
  logic [SUM_W-1:0] qry_pre;
  logic             out_load;

  logic             ram_we;
  logic [AW-1:0]    ram_waddr;
  logic [AW-1:0]    ram_raddr;
  logic [SUM_W-1:0] ram_wdata_o, ram_wdata_s;
  logic [SUM_W-1:0] ram_rdata_o, ram_rdata_s;

  rfw_ram #(.WIDTH(SUM_W), .DEPTH(DEPTH)) u_offset_ram (
    .clk     (clk),
    .wr_en   (ram_we),
    .wr_addr (ram_waddr),
    .wr_data (ram_wdata_o),
    .rd_addr (ram_raddr),
    .rd_data (ram_rdata_o)
  );

  rfw_ram #(.WIDTH(SUM_W), .DEPTH(DEPTH)) u_slope_ram (
    .clk     (clk),
    .wr_en   (ram_we),
    .wr_addr (ram_waddr),
    .wr_data (ram_wdata_s),
    .rd_addr (ram_raddr),
    .rd_data (ram_rdata_s)
  );

  // configuration port
  assign pready = 1'b1;
  assign prdata = (paddr[CFG_ADDR_W-1:2] == REG_ACTIVE_SIZE) ?
                  {{(CFG_DATA_W-POS_W){1'b0}}, size_r} : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      size_r <= ACTIVE_SIZE_RST;
    end else if (psel && penable && pwrite && pready &&
                 paddr[CFG_ADDR_W-1:2] == REG_ACTIVE_SIZE) begin
      size_r <= pwdata[POS_W-1:0];
    end
  end

  assign in_stall  = (state_r != ST_IDLE);
  assign in_accept = in_valid && !in_stall;
  assign out_valid = out_valid_r;
  assign out_range_sum = out_sum_r;

  assign is_query = (req_r == REQ_QUERY);

  // update walks stop at min(active_size, MAX_POSITIONS) + 2
  assign size_cap = (IDX_W'(size_r) > IDX_W'(MAX_POSITIONS)) ?
                    IDX_W'(MAX_POSITIONS) : IDX_W'(size_r);
  assign limit    = size_cap + IDX_W'(2);

  assign id_low  = id_r & (~id_r + IDX_W'(1));
  assign upd_nid = id_r + id_low;
  assign qry_nid = id_r - id_low;

  // shared multiplier: 64-bit operand times an 11-bit position, half per cycle
  assign x64     = {{(SUM_W-VAL_W){x_r[VAL_W-1]}}, x_r};
  assign mul_a64 = is_query ? acc_s_r : x64;
  assign mul_a32 = (state_r == ST_MUL_HI) ? mul_a64[SUM_W-1:VAL_W] : mul_a64[VAL_W-1:0];
  assign mul_b   = (is_query ^ walk_r) ? right_r : left_r - POS_W'(1);
  assign mul_p   = PROD_W'(mul_a32) * PROD_W'(mul_b);

  assign qry_pre  = acc_o_r + prod_r;
  assign out_load = (state_r == ST_OUT) && (!out_valid_r || !out_stall);

  always_comb begin
    state_nxt    = state_r;
    req_nxt      = req_r;
    left_nxt     = left_r;
    right_nxt    = right_r;
    x_nxt        = x_r;
    walk_nxt     = walk_r;
    id_nxt       = id_r;
    hit_nxt      = hit_r;
    amt_o_nxt    = amt_o_r;
    amt_s_nxt    = amt_s_r;
    acc_o_nxt    = acc_o_r;
    acc_s_nxt    = acc_s_r;
    prod_nxt     = prod_r;
    hi_nxt       = hi_r;
    clr_addr_nxt = clr_addr_r;
    ram_we       = 1'b0;
    ram_waddr    = id_r[AW-1:0];
    ram_raddr    = id_r[AW-1:0];
    ram_wdata_o  = ram_rdata_o + amt_o_r;
    ram_wdata_s  = ram_rdata_s + amt_s_r;

    case (state_r)
      ST_CLEAR: begin
        ram_we       = 1'b1;
        ram_waddr    = clr_addr_r;
        ram_wdata_o  = '0;
        ram_wdata_s  = '0;
        clr_addr_nxt = clr_addr_r + AW'(1);
        if (clr_addr_r == AW'(DEPTH - 1)) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_accept) begin
          req_nxt   = in_req_type;
          left_nxt  = in_left;
          right_nxt = in_right;
          x_nxt     = in_value;
          walk_nxt  = 1'b0;
          case (in_req_type)
            REQ_ADD: begin
              state_nxt = ST_MUL_LO;
            end
            REQ_QUERY: begin
              id_nxt    = IDX_W'(in_right);
              acc_o_nxt = '0;
              acc_s_nxt = '0;
              state_nxt = ST_QRY_RD;
            end
            REQ_CLEAR: begin
              clr_addr_nxt = '0;
              state_nxt    = ST_CLEAR;
            end
            default: begin
              state_nxt = ST_IDLE;
            end
          endcase
        end
      end
      ST_MUL_LO: begin
        prod_nxt  = SUM_W'(mul_p);
        state_nxt = ST_MUL_HI;
      end
      ST_MUL_HI: begin
        prod_nxt  = prod_r + {mul_p[VAL_W-1:0], {VAL_W{1'b0}}};
        state_nxt = ST_FIN;
      end
      ST_FIN: begin
        if (is_query) begin
          acc_o_nxt = '0;
          acc_s_nxt = '0;
          if (!walk_r) begin
            hi_nxt    = qry_pre;
            walk_nxt  = 1'b1;
            id_nxt    = (left_r == '0) ? '0 : IDX_W'(left_r) - IDX_W'(1);
            state_nxt = ST_QRY_RD;
          end else begin
            hi_nxt    = hi_r - qry_pre;
            state_nxt = ST_OUT;
          end
        end else begin
          // offset store takes -x*(left-1) at left, x*right past the right end
          amt_o_nxt = walk_r ? prod_r : SUM_W'(0) - prod_r;
          amt_s_nxt = walk_r ? SUM_W'(0) - x64 : x64;
          id_nxt    = walk_r ? IDX_W'(right_r) + IDX_W'(1) : IDX_W'(left_r);
          state_nxt = ST_UPD_RD;
        end
      end
      ST_UPD_RD: begin
        if (id_r == '0 || id_r >= limit) begin
          walk_nxt  = 1'b1;
          state_nxt = walk_r ? ST_IDLE : ST_MUL_LO;
        end else begin
          state_nxt = ST_UPD_WR;
        end
      end
      ST_UPD_WR: begin
        ram_we = 1'b1;
        id_nxt = upd_nid;
        if (upd_nid < limit) begin
          state_nxt = ST_UPD_RD;
        end else begin
          walk_nxt  = 1'b1;
          state_nxt = walk_r ? ST_IDLE : ST_MUL_LO;
        end
      end
      ST_QRY_RD: begin
        hit_nxt = (id_r < IDX_W'(DEPTH));
        if (id_r == '0) begin
          state_nxt = ST_MUL_LO;
        end else begin
          state_nxt = ST_QRY_ACC;
        end
      end
      ST_QRY_ACC: begin
        // indices past the store read as zero
        if (hit_r) begin
          acc_o_nxt = acc_o_r + ram_rdata_o;
          acc_s_nxt = acc_s_r + ram_rdata_s;
        end
        id_nxt    = qry_nid;
        state_nxt = (qry_nid == '0) ? ST_MUL_LO : ST_QRY_RD;
      end
      ST_OUT: begin
        if (out_load) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r && out_stall;
    out_sum_nxt   = out_sum_r;
    if (out_load) begin
      out_valid_nxt = 1'b1;
      out_sum_nxt   = hi_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      clr_addr_r  <= '0;
      walk_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_addr_r  <= clr_addr_nxt;
      walk_r      <= walk_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    req_r     <= req_nxt;
    left_r    <= left_nxt;
    right_r   <= right_nxt;
    x_r       <= x_nxt;
    id_r      <= id_nxt;
    hit_r     <= hit_nxt;
    amt_o_r   <= amt_o_nxt;
    amt_s_r   <= amt_s_nxt;
    acc_o_r   <= acc_o_nxt;
    acc_s_r   <= acc_s_nxt;
    prod_r    <= prod_nxt;
    hi_r      <= hi_nxt;
    out_sum_r <= out_sum_nxt;
  end

  `ASSERT_IMPLY(a_upd_in_range, clk, rst_n, state_r == ST_UPD_WR, id_r < limit && id_r != '0, "update write outside active range")
  `ASSERT_IMPLY(a_out_from_query, clk, rst_n, $rose(out_valid_r), $past(state_r) == ST_OUT, "result posted outside output step")
  `ASSERT_IMPLY(a_qry_nonzero, clk, rst_n, state_r == ST_QRY_ACC, id_r != '0 && is_query, "prefix step on index zero")

endmodule
